// ----- rtl/core/mme_pkg.sv -----
//------------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the matrix multiply engine: operation codes,
// register map, controller states and the controller/datapath interface.
//------------------------------------------------------------------------------
package mme_pkg;

  // Fixed field widths
  localparam int IDX_W     = 4;   // row / column index
  localparam int CFG_W     = 5;   // size registers
  localparam int IN_ELEM_W = 16;  // element as it arrives
  localparam int PROD_BITS = 35;  // result width, saturating
  localparam int FUNC_W    = 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WR_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_P = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic             wr_a;      // store element in A
    logic             wr_b;      // store element in B
    logic             load;      // capture indices, clear accumulator
    logic             issue;     // read one term pair at index k
    logic [CFG_W-1:0] k;
    logic             emit_err;  // error result from the live inputs
    logic             emit_sum;  // finished dot product
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic              ok;         // indices in range for this func
    logic [FUNC_W-1:0] func;
    logic              pipe_busy;  // terms still in flight
  } dp_status_t;

endpackage

// ----- rtl/core/mme_regs.sv -----
//------------------------------------------------------------------------------
// mme_regs
// APB size registers; presents the sizes clipped to MAX_DIM.
//------------------------------------------------------------------------------
module mme_regs import mme_pkg::*; #(
  parameter int MAX_DIM = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CFG_W-1:0]   nr_o,
  output logic [CFG_W-1:0]   nk_o,
  output logic [CFG_W-1:0]   nc_o
);

  logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_W'(1);
      inner_dim_q <= CFG_W'(1);
      cols_b_q    <= CFG_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROWS_A:    rows_a_q    <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_dim_q <= pwdata[CFG_W-1:0];
        REG_COLS_B:    cols_b_q    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROWS_A:    prdata = PDATA_W'(rows_a_q);
      REG_INNER_DIM: prdata = PDATA_W'(inner_dim_q);
      REG_COLS_B:    prdata = PDATA_W'(cols_b_q);
      default:       prdata = '0;
    endcase
  end

  // clip to store size
  assign nr_o = (int'(rows_a_q) > MAX_DIM)    ? CFG_W'(MAX_DIM) : rows_a_q;
  assign nk_o = (int'(inner_dim_q) > MAX_DIM) ? CFG_W'(MAX_DIM) : inner_dim_q;
  assign nc_o = (int'(cols_b_q) > MAX_DIM)    ? CFG_W'(MAX_DIM) : cols_b_q;

endmodule

// ----- rtl/core/mme_dp.sv -----
//------------------------------------------------------------------------------
// mme_dp
// Datapath: A and B stores, range check, multiply-accumulate pipeline and
// result registers.
//------------------------------------------------------------------------------
module mme_dp import mme_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [FUNC_W-1:0]           func_i,
  input  logic [IDX_W-1:0]            row_index_i,
  input  logic [IDX_W-1:0]            col_index_i,
  input  logic signed [IN_ELEM_W-1:0] element_value_i,
  input  logic [CFG_W-1:0]            nr_i,
  input  logic [CFG_W-1:0]            nk_i,
  input  logic [CFG_W-1:0]            nc_i,
  input  ctrl_cmd_t                   cmd_i,
  output dp_status_t                  status_o,
  output logic                        result_valid_o,
  output logic [IDX_W-1:0]            out_row_o,
  output logic [IDX_W-1:0]            out_col_o,
  output logic signed [PROD_BITS-1:0] product_value_o,
  output logic                        status_bit_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * ELEM_BITS;
  localparam int SW    = ((PROD_BITS > PW) ? PROD_BITS : PW) + 1;
  localparam logic signed [SW-1:0] PMAX =
    {{(SW-PROD_BITS+1){1'b0}}, {(PROD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] PMIN = ~PMAX;

  logic [ELEM_BITS-1:0]        mem_a_q [DEPTH];
  logic [ELEM_BITS-1:0]        mem_b_q [DEPTH];
  logic signed [ELEM_BITS-1:0] rd_a_q, rd_b_q;
  logic signed [PW-1:0]        prod_q;
  logic signed [PROD_BITS-1:0] acc_q, acc_d;
  logic signed [SW-1:0]        sum;
  logic                        v1_q, v2_q;
  logic [IDX_W-1:0]            row_q, col_q;
  logic [AW-1:0]               wr_addr, rd_addr_a, rd_addr_b;
  logic [31:0]                 elem_ext;
  logic [ELEM_BITS-1:0]        elem;
  logic                        ok;
  logic                        valid_q, stat_q;
  logic [IDX_W-1:0]            orow_q, ocol_q;
  logic signed [PROD_BITS-1:0] oval_q;

  // range check against the clipped sizes
  always_comb begin
    unique case (func_i)
      FUNC_WR_A: ok = ({1'b0, row_index_i} < nr_i) && ({1'b0, col_index_i} < nk_i);
      FUNC_WR_B: ok = ({1'b0, row_index_i} < nk_i) && ({1'b0, col_index_i} < nc_i);
      FUNC_RD_P: ok = ({1'b0, row_index_i} < nr_i) && ({1'b0, col_index_i} < nc_i);
      default:   ok = 1'b0;
    endcase
  end

  assign status_o.ok        = ok;
  assign status_o.func      = func_i;
  assign status_o.pipe_busy = v1_q | v2_q;

  // sign-extend, then wrap to the stored width
  assign elem_ext = {{(32-IN_ELEM_W){element_value_i[IN_ELEM_W-1]}}, element_value_i};
  assign elem     = elem_ext[ELEM_BITS-1:0];

  assign wr_addr   = AW'(int'(row_index_i) * MAX_DIM + int'(col_index_i));
  assign rd_addr_a = AW'(int'(row_q) * MAX_DIM + int'(cmd_i.k));
  assign rd_addr_b = AW'(int'(cmd_i.k) * MAX_DIM + int'(col_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a_q[wr_addr] <= elem;
    end
    if (cmd_i.issue) begin
      rd_a_q <= mem_a_q[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      mem_b_q[wr_addr] <= elem;
    end
    if (cmd_i.issue) begin
      rd_b_q <= mem_b_q[rd_addr_b];
    end
  end

  // saturating accumulate
  assign sum = {{(SW-PROD_BITS){acc_q[PROD_BITS-1]}}, acc_q}
             + {{(SW-PW){prod_q[PW-1]}}, prod_q};

  always_comb begin
    if (sum > PMAX) begin
      acc_d = PMAX[PROD_BITS-1:0];
    end else if (sum < PMIN) begin
      acc_d = PMIN[PROD_BITS-1:0];
    end else begin
      acc_d = sum[PROD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1_q    <= cmd_i.issue;
      v2_q    <= v1_q;
      valid_q <= cmd_i.emit_err | cmd_i.emit_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= rd_a_q * rd_b_q;
    end
    if (cmd_i.load) begin
      row_q <= row_index_i;
      col_q <= col_index_i;
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_d;
    end
    if (cmd_i.emit_err) begin
      orow_q <= row_index_i;
      ocol_q <= col_index_i;
      oval_q <= '0;
      stat_q <= 1'b1;
    end else if (cmd_i.emit_sum) begin
      orow_q <= row_q;
      ocol_q <= col_q;
      oval_q <= acc_q;
      stat_q <= 1'b0;
    end
  end

  assign result_valid_o  = valid_q;
  assign out_row_o       = orow_q;
  assign out_col_o       = ocol_q;
  assign product_value_o = oval_q;
  assign status_bit_o    = stat_q;

endmodule

// ----- rtl/core/mme_ctrl.sv -----
//------------------------------------------------------------------------------
// mme_ctrl
// Controller: decodes accepted items and sequences the term index k.
//------------------------------------------------------------------------------
module mme_ctrl import mme_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CFG_W-1:0] nk_i,
  input  dp_status_t       status_i,
  output ctrl_cmd_t        cmd_o,
  output logic             busy
);

  ctrl_state_e      state_q, state_d;
  logic [CFG_W-1:0] k_q, k_d;
  logic             rd_go;

  assign rd_go = start && (status_i.func == FUNC_RD_P) && status_i.ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (rd_go) begin
          state_d = (nk_i == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        k_d = k_q + CFG_W'(1);
        if (k_q == nk_i - CFG_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o   = '0;
    cmd_o.k = k_q;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (status_i.func)
            FUNC_WR_A: begin
              cmd_o.wr_a     = status_i.ok;
              cmd_o.emit_err = !status_i.ok;
            end
            FUNC_WR_B: begin
              cmd_o.wr_b     = status_i.ok;
              cmd_o.emit_err = !status_i.ok;
            end
            FUNC_RD_P: begin
              cmd_o.load     = status_i.ok;
              cmd_o.emit_err = !status_i.ok;
            end
            default: ;
          endcase
        end
      end
      ST_RUN:   cmd_o.issue    = 1'b1;
      ST_DRAIN: cmd_o.emit_sum = !status_i.pipe_busy;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q < nk_i))
    else $error("term index beyond inner size");

  a_read_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && rd_go) |=> busy)
    else $error("accepted product read did not start");

  a_drain_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && status_i.pipe_busy) |=> (state_q == ST_DRAIN))
    else $error("left drain with terms in flight");

  a_no_issue_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> !$past(cmd_o.issue) || $past(state_q) == ST_RUN)
    else $error("term issued outside run");
`endif

endmodule

// ----- rtl/core/matrix_multiply_engine_core.sv -----
//------------------------------------------------------------------------------
// matrix_multiply_engine_core
// Integer matrix multiply engine: holds A and B in two local stores and
// returns one saturated 35-bit dot product per product read.
//------------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// -------   ---------  ----------------------------  ------------------------
// command   in         start && !busy                func, row/col index, elem
// result    out        result_valid_o (one cycle)    row, col, product, status
// config    in         APB, psel&penable&pwrite      rows_a, inner_dim, cols_b
//
// Writes to A or B go straight into the store; an out-of-range item answers
// with an error result in the next cycle, and busy stays low for both.
// A product read runs one MAC term per cycle through the registered store
// read, the multiplier stage and the accumulator, then the result register,
// and issues no terms when inner_dim is zero; busy is high while the read is
// in progress and low again in the cycle in which the result is shown.
// The stores have no reset; only control state and the size registers reset.
// Results cannot be held off: each is shown for exactly one cycle.
//------------------------------------------------------------------------------
module matrix_multiply_engine_core import mme_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [FUNC_W-1:0]           func_i,
  input  logic [IDX_W-1:0]            row_index_i,
  input  logic [IDX_W-1:0]            col_index_i,
  input  logic signed [IN_ELEM_W-1:0] element_value_i,
  // result channel
  output logic                        result_valid_o,
  output logic [IDX_W-1:0]            out_row_o,
  output logic [IDX_W-1:0]            out_col_o,
  output logic signed [PROD_BITS-1:0] product_value_o,
  output logic                        status_o,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [PDATA_W-1:0]          pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready
);

  logic [CFG_W-1:0] nr, nk, nc;   // sizes clipped to MAX_DIM
  ctrl_cmd_t        cmd;
  dp_status_t       dp_status;

  mme_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .nr_o    (nr),
    .nk_o    (nk),
    .nc_o    (nc)
  );

  // sequencer: decode, term counter, drain
  mme_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .nk_i     (nk),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // stores, MAC pipeline, result registers
  mme_dp #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .nr_i            (nr),
    .nk_i            (nk),
    .nc_i            (nc),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .result_valid_o  (result_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .status_bit_o    (status_o)
  );

endmodule
